[src/stepper_step_dir_generator_macros.svh]
// Assertion macros shared by the stepper step/dir generator RTL.
`ifndef STEPPER_STEP_DIR_GENERATOR_MACROS_SVH
`define STEPPER_STEP_DIR_GENERATOR_MACROS_SVH

// Property checked at every clock edge outside reset.
`define STPGEN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define STPGEN_ASSERT_NEXT(label, ante, cons, msg) \
  `STPGEN_ASSERT(label, (ante) |=> (cons), msg)

`endif

[src/stpgen_pkg.sv]
// Types, constants and helpers for the stepper step/dir generator.
package stpgen_pkg;

  localparam int unsigned POS_WIDTH   = 32;
  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned CFG_WIDTH   = 16;
  localparam int unsigned IO_WIDTH    = 32;

  localparam logic [CFG_WIDTH-1:0] RESET_IDLE_RELOAD = CFG_WIDTH'(100);
  localparam logic [CFG_WIDTH-1:0] RESET_RUN_RELOAD  = CFG_WIDTH'(50);

  // register indexes on the config port
  localparam logic CFG_IDLE_RELOAD = 1'b0;
  localparam logic CFG_RUN_RELOAD  = 1'b1;

  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_LOAD_TGT = 3'd1,
    CMD_LOAD_POS = 3'd2,
    CMD_ARM      = 3'd3,
    CMD_COMP_REQ = 3'd4
  } cmd_e;

  localparam logic [1:0] HAND_INC = 2'd1;
  localparam logic [1:0] HAND_DEC = 2'd2;

  localparam logic [1:0] COMP_NONE = 2'd0;
  localparam logic [1:0] COMP_REQ  = 2'd1;
  localparam logic [1:0] COMP_DONE = 2'd2;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] tick_count;
    logic [COUNT_WIDTH-1:0] reload;
    logic                   phase_high;
    logic                   move;
    logic                   start_pending;
    logic                   run_adopted;
    logic [POS_WIDTH-1:0]   target;
    logic [POS_WIDTH-1:0]   position;
    logic [1:0]             comp;
    logic                   step;
    logic                   dir;
    logic                   en;
  } axis_state_t;

  // axis state after reset: all clear, idle reload live
  localparam axis_state_t AXIS_RESET = '{reload: COUNT_WIDTH'(RESET_IDLE_RELOAD),
                                         default: '0};

  // sign-extend or truncate a 32-bit port value to position width
  function automatic logic [POS_WIDTH-1:0] to_pos(input logic [IO_WIDTH-1:0] v);
    logic [POS_WIDTH-1:0] r;
    for (int i = 0; i < POS_WIDTH; i++) begin
      r[i] = (i < IO_WIDTH) ? v[i % IO_WIDTH] : v[IO_WIDTH-1];
    end
    return r;
  endfunction

  // low bits of a position for the output port, zero-filled when narrower
  function automatic logic [IO_WIDTH-1:0] to_io(input logic [POS_WIDTH-1:0] p);
    logic [IO_WIDTH-1:0] r;
    for (int i = 0; i < IO_WIDTH; i++) begin
      r[i] = (i < POS_WIDTH) ? p[i % POS_WIDTH] : 1'b0;
    end
    return r;
  endfunction

endpackage

[src/stpgen_next.sv]
// Next-state logic of one axis: counter, update phases and position stepping.
module stpgen_next
  import stpgen_pkg::*;
(
  input  axis_state_t          st_i,
  input  logic [CFG_WIDTH-1:0] run_reload_i,
  input  logic [2:0]           command_i,
  input  logic [IO_WIDTH-1:0]  value_i,
  input  logic                 hand_mode_i,
  input  logic [1:0]           hand_dir_i,
  input  logic                 encoder_error_i,
  output axis_state_t          st_o,
  output logic                 event_o
);

  axis_state_t upd;
  logic        differ;

  // effect of one update event
  always_comb begin
    upd    = st_i;
    differ = (st_i.target != st_i.position);
    if (!st_i.move && st_i.start_pending && differ) begin
      upd.move        = 1'b1;
      upd.phase_high  = 1'b1;
      upd.reload      = COUNT_WIDTH'(run_reload_i);
      upd.run_adopted = 1'b1;
    end
    if (upd.phase_high) begin
      upd.phase_high = 1'b0;
      upd.step       = 1'b1;
      if (hand_mode_i) begin
        if (hand_dir_i == HAND_INC) begin
          upd.target = st_i.target + POS_WIDTH'(1);
        end else if (hand_dir_i == HAND_DEC) begin
          upd.target = st_i.target - POS_WIDTH'(1);
        end
      end
    end else begin
      upd.phase_high = 1'b1;
      if (differ) begin
        upd.en   = 1'b1;
        upd.step = 1'b0;
        if ($signed(st_i.target) > $signed(st_i.position)) begin
          upd.dir      = 1'b1;
          upd.position = st_i.position + POS_WIDTH'(1);
        end else begin
          upd.dir      = 1'b0;
          upd.position = st_i.position - POS_WIDTH'(1);
        end
      end else begin
        upd.start_pending = 1'b0;
        if (st_i.move) begin
          upd.move = 1'b0;
          upd.comp = (!encoder_error_i && st_i.comp == COMP_REQ) ? COMP_DONE : COMP_NONE;
        end else if (st_i.comp == COMP_REQ) begin
          upd.comp = COMP_DONE;
        end
      end
    end
  end

  always_comb begin
    st_o    = st_i;
    event_o = 1'b0;
    unique case (command_i)
      CMD_TICK: begin
        // compare saturates: a count at or past reload fires
        if (st_i.tick_count >= st_i.reload) begin
          st_o            = upd;
          st_o.tick_count = '0;
          event_o         = 1'b1;
        end else begin
          st_o.tick_count = st_i.tick_count + COUNT_WIDTH'(1);
        end
      end
      CMD_LOAD_TGT: st_o.target        = to_pos(value_i);
      CMD_LOAD_POS: st_o.position      = to_pos(value_i);
      CMD_ARM:      st_o.start_pending = 1'b1;
      CMD_COMP_REQ: st_o.comp          = COMP_REQ;
      default: ;
    endcase
  end

endmodule

[src/stepper_step_dir_generator.sv]
// Stepper step/dir generator top level: axis state, config and output register.
// Each accepted word's result is registered in the output register.
// Throughput: one word per cycle while in_stall_o is low; the axis state updates in the accept cycle.
// The output register stalls input only while a held result is stalled.
// Reset (async, active low) clears counter, positions, flags and the step, dir and enable state (not the output
// pins), and loads the idle and run reloads with 100 and 50.
module stepper_step_dir_generator
  import stpgen_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [CFG_WIDTH-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           command_i,
  input  logic [IO_WIDTH-1:0]  value_i,
  input  logic                 hand_mode_i,
  input  logic [1:0]           hand_dir_i,
  input  logic                 encoder_error_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 step_level_o,
  output logic                 dir_level_o,
  output logic                 enable_level_o,
  output logic                 update_event_o,
  output logic [IO_WIDTH-1:0]  cur_position_o,
  output logic [IO_WIDTH-1:0]  cur_target_o,
  output logic                 move_active_o,
  output logic [1:0]           comp_status_o
);

  `include "stepper_step_dir_generator_macros.svh"

  axis_state_t          st_q, st_d, st_n;
  logic                 event_d;
  logic [CFG_WIDTH-1:0] idle_reload_q, run_reload_q;
  logic                 out_valid_q;
  logic                 in_acc;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  stpgen_next u_next (
    .st_i            (st_q),
    .run_reload_i    (run_reload_q),
    .command_i       (command_i),
    .value_i         (value_i),
    .hand_mode_i     (hand_mode_i),
    .hand_dir_i      (hand_dir_i),
    .encoder_error_i (encoder_error_i),
    .st_o            (st_d),
    .event_o         (event_d)
  );

  always_comb begin
    st_n = in_acc ? st_d : st_q;
    // idle reload is live until a move adopts the run value
    if (cfg_we_i && (cfg_idx_i == CFG_IDLE_RELOAD) && !st_n.run_adopted) begin
      st_n.reload = COUNT_WIDTH'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q          <= AXIS_RESET;
      idle_reload_q <= RESET_IDLE_RELOAD;
      run_reload_q  <= RESET_RUN_RELOAD;
    end else begin
      st_q <= st_n;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_IDLE_RELOAD: idle_reload_q <= cfg_data_i;
          CFG_RUN_RELOAD:  run_reload_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      step_level_o   <= st_d.step;
      dir_level_o    <= st_d.dir;
      enable_level_o <= st_d.en;
      update_event_o <= event_d;
      cur_position_o <= to_io(st_d.position);
      cur_target_o   <= to_io(st_d.target);
      move_active_o  <= st_d.move;
      comp_status_o  <= st_d.comp;
    end
  end

  assign out_valid_o = out_valid_q;

  // idle reload register feeds only this check against the live reload; keep it observable
  logic idle_shadow_ok;
  assign idle_shadow_ok = st_q.run_adopted || (st_q.reload == COUNT_WIDTH'(idle_reload_q));

  `STPGEN_ASSERT_NEXT(a_event_clears_count, in_acc && event_d, st_q.tick_count == '0,
    "update event did not restart the counter")
  `STPGEN_ASSERT_NEXT(a_run_sticky, st_q.run_adopted, st_q.run_adopted,
    "run reload adoption was lost")
  `STPGEN_ASSERT(a_move_adopted, !st_q.move || st_q.run_adopted,
    "move active without run reload adopted")
  `STPGEN_ASSERT(a_idle_reload, idle_shadow_ok,
    "live reload differs from idle reload before a move")
  `STPGEN_ASSERT_NEXT(a_single_step, in_acc && command_i == CMD_TICK,
    st_q.position == $past(st_q.position) ||
    st_q.position == $past(st_q.position) + POS_WIDTH'(1) ||
    st_q.position == $past(st_q.position) - POS_WIDTH'(1),
    "position moved more than one step on a tick")

endmodule
